// File: rtl/vff_pkg.sv
// ----------------------------------------------------------------------------
// vff_pkg
// Types, constants, saturating arithmetic and the sequencer microprogram
// for the viscous face flux block.
// ----------------------------------------------------------------------------
package vff_pkg;

    localparam int MAX_SPECIES_DEF = 8;
    localparam logic signed [63:0] C23_Q48 = 64'sd187649984473771;
    localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;
    localparam logic [6:0] SP_START = 7'd80;
    localparam logic [5:0] SP_BASE0 = 6'd17;

    typedef struct packed {
        logic              req_type;
        logic              side;
        logic [5:0]        slot;
        logic signed [63:0] operand_value;
    } t_req;

    typedef struct packed {
        logic [3:0]         component;
        logic signed [63:0] flux_value;
        logic               last;
    } t_res;

    typedef enum logic [3:0] {
        OP_FACE, OP_FACEB, OP_NORM, OP_C23, OP_ADD, OP_SUB, OP_NEG, OP_MUL,
        OP_EMIT0, OP_EMIT, OP_EMITE, OP_EMITS, OP_NEXT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [3:0] dst;
        logic [3:0] a;
        logic [3:0] b;
        logic [5:0] imm;
    } t_ins;

    function automatic logic signed [63:0] sat65(input logic signed [64:0] s);
        if (s[64] != s[63]) begin
            return s[64] ? Q_MIN : Q_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        return sat65(65'(a) + 65'(b));
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        return sat65(65'(a) - 65'(b));
    endfunction

    function automatic logic signed [63:0] sat_neg(input logic signed [63:0] a);
        return (a == Q_MIN) ? Q_MAX : -a;
    endfunction

    // floor((a+b)/2), exact
    function automatic logic signed [63:0] avg2(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        return s[64:1];
    endfunction

    function automatic t_ins mk(input t_op op, input int d, input int a,
                                input int b, input int imm);
        t_ins r;
        r.op  = op;
        r.dst = 4'(d);
        r.a   = 4'(a);
        r.b   = 4'(b);
        r.imm = 6'(imm);
        return r;
    endfunction

    // Temporaries: 0 mu, 1 kappa, 2..4 normal, 5 c23mu, 6 txx, 7 txy, 8 txz,
    // 9 tyy, 10 tyz, 11 tzz, 12..15 scratch.
    function automatic t_ins prog(input logic [6:0] pc);
        t_ins i;
        unique case (pc)
            7'd0:  i = mk(OP_FACE, 0, 0, 0, 0);
            7'd1:  i = mk(OP_FACE, 1, 0, 0, 1);
            7'd2:  i = mk(OP_NORM, 2, 0, 0, 60);
            7'd3:  i = mk(OP_NORM, 3, 0, 0, 61);
            7'd4:  i = mk(OP_NORM, 4, 0, 0, 62);
            7'd5:  i = mk(OP_C23, 12, 0, 0, 0);
            7'd6:  i = mk(OP_MUL, 5, 12, 0, 0);
            7'd7:  i = mk(OP_FACE, 12, 0, 0, 2);
            7'd8:  i = mk(OP_FACE, 13, 0, 0, 6);
            7'd9:  i = mk(OP_FACE, 14, 0, 0, 10);
            7'd10: i = mk(OP_ADD, 15, 12, 12, 0);
            7'd11: i = mk(OP_SUB, 15, 15, 13, 0);
            7'd12: i = mk(OP_SUB, 15, 15, 14, 0);
            7'd13: i = mk(OP_MUL, 6, 5, 15, 0);
            7'd14: i = mk(OP_NEG, 15, 12, 0, 0);
            7'd15: i = mk(OP_ADD, 9, 13, 13, 0);
            7'd16: i = mk(OP_ADD, 15, 15, 9, 0);
            7'd17: i = mk(OP_SUB, 15, 15, 14, 0);
            7'd18: i = mk(OP_MUL, 9, 5, 15, 0);
            7'd19: i = mk(OP_NEG, 15, 12, 0, 0);
            7'd20: i = mk(OP_SUB, 15, 15, 13, 0);
            7'd21: i = mk(OP_ADD, 11, 14, 14, 0);
            7'd22: i = mk(OP_ADD, 15, 15, 11, 0);
            7'd23: i = mk(OP_MUL, 11, 5, 15, 0);
            7'd24: i = mk(OP_FACE, 12, 0, 0, 3);
            7'd25: i = mk(OP_FACE, 13, 0, 0, 5);
            7'd26: i = mk(OP_ADD, 15, 12, 13, 0);
            7'd27: i = mk(OP_MUL, 7, 0, 15, 0);
            7'd28: i = mk(OP_FACE, 12, 0, 0, 4);
            7'd29: i = mk(OP_FACE, 13, 0, 0, 8);
            7'd30: i = mk(OP_ADD, 15, 12, 13, 0);
            7'd31: i = mk(OP_MUL, 8, 0, 15, 0);
            7'd32: i = mk(OP_FACE, 12, 0, 0, 7);
            7'd33: i = mk(OP_FACE, 13, 0, 0, 9);
            7'd34: i = mk(OP_ADD, 15, 12, 13, 0);
            7'd35: i = mk(OP_MUL, 10, 0, 15, 0);
            7'd36: i = mk(OP_EMIT0, 0, 0, 0, 0);
            7'd37: i = mk(OP_MUL, 12, 6, 2, 0);
            7'd38: i = mk(OP_MUL, 13, 7, 3, 0);
            7'd39: i = mk(OP_ADD, 12, 12, 13, 0);
            7'd40: i = mk(OP_MUL, 13, 8, 4, 0);
            7'd41: i = mk(OP_ADD, 12, 12, 13, 0);
            7'd42: i = mk(OP_NEG, 12, 12, 0, 0);
            7'd43: i = mk(OP_EMIT, 0, 12, 0, 1);
            7'd44: i = mk(OP_MUL, 12, 7, 2, 0);
            7'd45: i = mk(OP_MUL, 13, 9, 3, 0);
            7'd46: i = mk(OP_ADD, 12, 12, 13, 0);
            7'd47: i = mk(OP_MUL, 13, 10, 4, 0);
            7'd48: i = mk(OP_ADD, 12, 12, 13, 0);
            7'd49: i = mk(OP_NEG, 12, 12, 0, 0);
            7'd50: i = mk(OP_EMIT, 0, 12, 0, 2);
            7'd51: i = mk(OP_MUL, 12, 8, 2, 0);
            7'd52: i = mk(OP_MUL, 13, 10, 3, 0);
            7'd53: i = mk(OP_ADD, 12, 12, 13, 0);
            7'd54: i = mk(OP_MUL, 13, 11, 4, 0);
            7'd55: i = mk(OP_ADD, 12, 12, 13, 0);
            7'd56: i = mk(OP_NEG, 12, 12, 0, 0);
            7'd57: i = mk(OP_EMIT, 0, 12, 0, 3);
            7'd58: i = mk(OP_FACE, 12, 0, 0, 11);
            7'd59: i = mk(OP_MUL, 12, 12, 2, 0);
            7'd60: i = mk(OP_FACE, 13, 0, 0, 12);
            7'd61: i = mk(OP_MUL, 13, 13, 3, 0);
            7'd62: i = mk(OP_ADD, 12, 12, 13, 0);
            7'd63: i = mk(OP_FACE, 13, 0, 0, 13);
            7'd64: i = mk(OP_MUL, 13, 13, 4, 0);
            7'd65: i = mk(OP_ADD, 12, 12, 13, 0);
            7'd66: i = mk(OP_MUL, 15, 1, 12, 0);
            7'd67: i = mk(OP_FACE, 12, 0, 0, 14);
            7'd68: i = mk(OP_MUL, 12, 12, 6, 0);
            7'd69: i = mk(OP_MUL, 12, 12, 2, 0);
            7'd70: i = mk(OP_FACE, 13, 0, 0, 15);
            7'd71: i = mk(OP_MUL, 13, 13, 7, 0);
            7'd72: i = mk(OP_MUL, 13, 13, 3, 0);
            7'd73: i = mk(OP_ADD, 12, 12, 13, 0);
            7'd74: i = mk(OP_FACE, 13, 0, 0, 16);
            7'd75: i = mk(OP_MUL, 13, 13, 8, 0);
            7'd76: i = mk(OP_MUL, 13, 13, 4, 0);
            7'd77: i = mk(OP_ADD, 12, 12, 13, 0);
            7'd78: i = mk(OP_SUB, 12, 12, 15, 0);
            7'd79: i = mk(OP_EMITE, 0, 12, 0, 4);
            7'd80: i = mk(OP_FACEB, 14, 0, 0, 0);
            7'd81: i = mk(OP_NEG, 14, 14, 0, 0);
            7'd82: i = mk(OP_FACEB, 12, 0, 0, 1);
            7'd83: i = mk(OP_MUL, 12, 12, 2, 0);
            7'd84: i = mk(OP_FACEB, 13, 0, 0, 2);
            7'd85: i = mk(OP_MUL, 13, 13, 3, 0);
            7'd86: i = mk(OP_ADD, 12, 12, 13, 0);
            7'd87: i = mk(OP_FACEB, 13, 0, 0, 3);
            7'd88: i = mk(OP_MUL, 13, 13, 4, 0);
            7'd89: i = mk(OP_ADD, 12, 12, 13, 0);
            7'd90: i = mk(OP_MUL, 12, 14, 12, 0);
            7'd91: i = mk(OP_EMITS, 0, 12, 0, 0);
            7'd92: i = mk(OP_NEXT, 0, 0, 0, 0);
            default: i = mk(OP_NEXT, 0, 0, 0, 0);
        endcase
        return i;
    endfunction

endpackage

// File: rtl/viscous_face_flux.sv
// ----------------------------------------------------------------------------
// viscous_face_flux
// Viscous, heat and species diffusion flux through one cell face, Q16.48.
// ----------------------------------------------------------------------------
// Load transaction: accepted only while idle; a new one may follow every cycle while idle.
// Compute transaction: microprogram over a 128-word operand memory and a
//   16-word scratch memory; each step passes through the issue and execute states,
//   and a multiply also through the multiply state. Busy until the final result:
//   five components, plus one per species less one. Results are one-cycle strobes.
// Synchronous active-low reset: sequencer idle, species count 1; the operand
//   memory is not cleared.
module viscous_face_flux #(
    parameter int MAX_SPECIES = vff_pkg::MAX_SPECIES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  vff_pkg::t_req i_req,
    output logic          o_res_valid,
    output vff_pkg::t_res o_res,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [3:0]    i_cfg_data
);
    import vff_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_EXEC, S_MUL} t_state;

    t_state r_state;
    logic [6:0] r_pc;
    logic [2:0] r_cnt;
    logic [3:0] r_n, r_nsp, r_species;
    logic [5:0] r_base;
    logic r_neg;
    logic [63:0] r_ma, r_mb, r_pp;
    logic [1:0] r_pidx;
    logic [127:0] r_acc;
    logic r_res_valid;
    t_res r_res;

    // Operand memory, index side*64+slot; scratch memory for temporaries
    logic signed [63:0] m_store [128];
    logic signed [63:0] m_tmp [16];
    logic signed [63:0] r_slo, r_shi, r_ta, r_tb;

    t_ins ins;
    logic [5:0] rd_slot;
    logic ld_acc, wside;
    logic tw;
    logic signed [63:0] twd, face_v, mul_v;
    logic [3:0] ns_clamp, nsp;
    logic [1:0] pidx;
    logic [31:0] ah, bh;
    logic [1:0] sh;
    logic [63:0] mag;

    assign ins     = prog(r_pc);
    assign rd_slot = (ins.op == OP_FACEB) ? r_base + ins.imm : ins.imm;
    assign ld_acc  = i_start && (r_state == S_IDLE) && !i_req.req_type;
    // normal vector lives on the lower side only
    assign wside   = (i_req.slot >= 6'd60 && i_req.slot <= 6'd62) ? 1'b0 : i_req.side;
    assign face_v  = avg2(r_slo, r_shi);

    assign ns_clamp = (r_species > 4'(MAX_SPECIES)) ? 4'(MAX_SPECIES) : r_species;
    assign nsp      = (ns_clamp > 4'd1) ? ns_clamp - 4'd1 : 4'd0;

    always_ff @(posedge i_clk) begin
        if (ld_acc) begin
            m_store[{wside, i_req.slot}] <= i_req.operand_value;
        end
        r_slo <= m_store[{1'b0, rd_slot}];
        r_shi <= m_store[{1'b1, rd_slot}];
    end

    always_ff @(posedge i_clk) begin
        if (tw) begin
            m_tmp[ins.dst] <= twd;
        end
        r_ta <= m_tmp[ins.a];
        r_tb <= m_tmp[ins.b];
    end

    // Rounded, saturated product from the accumulated magnitude
    always_comb begin
        mag = r_acc[111:48];
        if (r_acc[127:112] != 16'd0) begin
            mul_v = r_neg ? Q_MIN : Q_MAX;
        end else if (r_neg) begin
            mul_v = (mag > 64'h8000_0000_0000_0000) ? Q_MIN : -$signed(mag);
        end else begin
            mul_v = mag[63] ? Q_MAX : $signed(mag);
        end
    end

    // Scratch write port
    always_comb begin
        tw  = 1'b0;
        twd = '0;
        if (r_state == S_EXEC) begin
            case (ins.op)
                OP_FACE, OP_FACEB: begin tw = 1'b1; twd = face_v; end
                OP_NORM: begin tw = 1'b1; twd = r_slo; end
                OP_C23:  begin tw = 1'b1; twd = C23_Q48; end
                OP_ADD:  begin tw = 1'b1; twd = sat_add(r_ta, r_tb); end
                OP_SUB:  begin tw = 1'b1; twd = sat_sub(r_ta, r_tb); end
                OP_NEG:  begin tw = 1'b1; twd = sat_neg(r_ta); end
                default: ;
            endcase
        end else if (r_state == S_MUL && r_cnt == 3'd6) begin
            tw  = 1'b1;
            twd = mul_v;
        end
    end

    // One 32x32 partial product a cycle, registered, then accumulated
    assign pidx = 2'(r_cnt - 3'd1);
    assign ah   = pidx[0] ? r_ma[63:32] : r_ma[31:0];
    assign bh   = pidx[1] ? r_mb[63:32] : r_mb[31:0];
    assign sh   = {1'b0, r_pidx[0]} + {1'b0, r_pidx[1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_cnt       <= '0;
            r_n         <= '0;
            r_nsp       <= '0;
            r_base      <= SP_BASE0;
            r_species   <= 4'd1;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            if (i_cfg_valid) begin
                r_species <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start && i_req.req_type) begin
                        r_pc    <= '0;
                        r_n     <= '0;
                        r_base  <= SP_BASE0;
                        r_nsp   <= nsp;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_pc    <= r_pc + 7'd1;
                    r_state <= S_ISSUE;
                    unique case (ins.op)
                        OP_MUL: begin
                            r_ma    <= r_ta[63] ? 64'(-r_ta) : r_ta;
                            r_mb    <= r_tb[63] ? 64'(-r_tb) : r_tb;
                            r_neg   <= r_ta[63] ^ r_tb[63];
                            r_acc   <= 128'd1 << 47;
                            r_cnt   <= 3'd1;
                            r_pc    <= r_pc;
                            r_state <= S_MUL;
                        end
                        OP_EMIT0: begin
                            r_res_valid <= 1'b1;
                            r_res <= '{component: 4'd0, flux_value: '0, last: 1'b0};
                        end
                        OP_EMIT: begin
                            r_res_valid <= 1'b1;
                            r_res <= '{component: ins.imm[3:0], flux_value: r_ta,
                                       last: 1'b0};
                        end
                        OP_EMITE: begin
                            r_res_valid <= 1'b1;
                            r_res <= '{component: ins.imm[3:0], flux_value: r_ta,
                                       last: (r_nsp == 4'd0)};
                            if (r_nsp == 4'd0) begin
                                r_state <= S_IDLE;
                            end
                        end
                        OP_EMITS: begin
                            r_res_valid <= 1'b1;
                            r_res <= '{component: r_n + 4'd5, flux_value: r_ta,
                                       last: (r_n + 4'd1 == r_nsp)};
                            if (r_n + 4'd1 == r_nsp) begin
                                r_state <= S_IDLE;
                            end
                        end
                        OP_NEXT: begin
                            r_n    <= r_n + 4'd1;
                            r_base <= r_base + 6'd4;
                            r_pc   <= SP_START;
                        end
                        default: ;
                    endcase
                end
                S_MUL: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt <= 3'd4) begin
                        r_pp   <= 64'(ah) * 64'(bh);
                        r_pidx <= pidx;
                    end
                    if (r_cnt >= 3'd2 && r_cnt <= 3'd5) begin
                        r_acc <= r_acc + ({64'd0, r_pp} << {sh, 5'd0});
                    end
                    if (r_cnt == 3'd6) begin
                        r_pc    <= r_pc + 7'd1;
                        r_state <= S_ISSUE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;

endmodule

// File: rtl/vff_checker.sv
// ----------------------------------------------------------------------------
// vff_checker
// Port-level checks on busy and result strobes of the face flux block.
// ----------------------------------------------------------------------------
module vff_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_start,
    input logic          o_busy,
    input vff_pkg::t_req i_req,
    input logic          o_res_valid,
    input vff_pkg::t_res o_res
);
    import vff_pkg::*;

    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && i_req.req_type |=> o_busy)
        else $error("compute transaction did not raise busy");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && !i_req.req_type |=> !o_busy)
        else $error("load transaction raised busy");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.last |-> o_busy)
        else $error("non-final result while idle");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.last |-> !o_busy)
        else $error("still busy after final result");

endmodule

bind viscous_face_flux vff_checker u_vff_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .i_req(i_req), .o_res_valid(o_res_valid), .o_res(o_res)
);
